// ===== src/tdf_pkg.sv =====
// Shared types and constants for the trial-division factorizer.
package tdf_pkg;

  localparam int unsigned ValueWidth    = 16;
  localparam int unsigned PrimeWidth    = 16;
  localparam int unsigned ExpWidth      = 5;
  localparam int unsigned MaxResults    = 6;
  localparam int unsigned SqWidth       = ValueWidth + 2;
  localparam int unsigned DivCntWidth   = $clog2(ValueWidth + 1);
  localparam int unsigned ResCntWidth   = $clog2(MaxResults + 1);
  localparam int unsigned FirstDivisor  = 2;

  typedef logic [ValueWidth-1:0] value_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } state_e;

  // Request into the serial divider.
  typedef struct packed {
    logic   start;
    value_t dividend;
    value_t divisor;
  } div_req_t;

  // Answer from the serial divider; done pulses for one cycle.
  typedef struct packed {
    logic   done;
    value_t quotient;
    value_t remainder;
  } div_rsp_t;

endpackage

// ===== src/tdf_divider.sv =====
// Restoring divider that resolves one quotient bit per cycle.
module tdf_divider (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tdf_pkg::div_req_t req_i,
  output tdf_pkg::div_rsp_t rsp_o
);
  import tdf_pkg::*;

  value_t                 rem_q, rem_d;
  value_t                 quo_q, quo_d;
  value_t                 dsr_q, dsr_d;
  logic [DivCntWidth-1:0] cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [ValueWidth:0]    rem_sh;
  logic [ValueWidth:0]    diff;
  logic                   fits;

  // The dividend leaves the top of quo_q while quotient bits enter at the bottom.
  assign rem_sh = {rem_q, quo_q[ValueWidth-1]};
  assign diff   = rem_sh - {1'b0, dsr_q};
  assign fits   = ~diff[ValueWidth];

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      cnt_d  = DivCntWidth'(ValueWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[ValueWidth-1:0] : rem_sh[ValueWidth-1:0];
      quo_d = {quo_q[ValueWidth-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== src/trial_division_factorizer_unit.sv =====
// Top level of the trial-division prime factorizer.
//
// Input channel: value_i with in_valid_i; the block raises in_stall_o while
// it works on an item, so one item is in flight at a time. Output channel:
// prime_o, exponent_o and last_o with out_valid_o, held by the receiver's
// out_stall_i. Each input gives one beat per distinct prime factor, in
// increasing order, the final beat carrying last_o. Inputs 0 and 1 give one
// beat of prime 0, exponent 0, last set.
// Candidate divisors run from 2 while their square does not exceed what is
// left of the value; a leftover above one is sent as the last prime. Every
// candidate costs a test in ST_TEST and one pass of the serial divider, and a
// divisor that divides costs one more pass per power.
// A stalled result sits in the output register; the search pauses only when
// the next result is ready and the register is still full.
// Reset returns the block to idle with no result pending.
module trial_division_factorizer_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tdf_pkg::ValueWidth-1:0]    value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tdf_pkg::PrimeWidth-1:0]    prime_o,
  output logic [tdf_pkg::ExpWidth-1:0]      exponent_o,
  output logic                              last_o
);
  import tdf_pkg::*;

  state_e                 state_q, state_d;
  value_t                 n_q, n_d;
  value_t                 dv_q, dv_d;
  logic [SqWidth-1:0]     sq_q, sq_d;
  logic [ExpWidth-1:0]    e_q, e_d;
  logic [ResCntWidth-1:0] cnt_q, cnt_d;
  value_t                 res_prime_q, res_prime_d;
  logic [ExpWidth-1:0]    res_exp_q, res_exp_d;
  logic                   res_last_q, res_last_d;
  logic                   out_valid_q, out_valid_d;
  logic [PrimeWidth-1:0]  out_prime_q, out_prime_d;
  logic [ExpWidth-1:0]    out_exp_q, out_exp_d;
  logic                   out_last_q, out_last_d;
  logic                   out_free;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  tdf_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_free = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    dv_d         = dv_q;
    sq_d         = sq_q;
    e_d          = e_q;
    cnt_d        = cnt_q;
    res_prime_d  = res_prime_q;
    res_exp_d    = res_exp_q;
    res_last_d   = res_last_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_prime_d  = out_prime_q;
    out_exp_d    = out_exp_q;
    out_last_d   = out_last_q;
    div_req.start    = 1'b0;
    div_req.dividend = n_q;
    div_req.divisor  = dv_q;
    in_stall_o   = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          n_d   = value_i;
          dv_d  = ValueWidth'(FirstDivisor);
          sq_d  = SqWidth'(FirstDivisor * FirstDivisor);
          e_d   = '0;
          cnt_d = '0;
          if (value_i < ValueWidth'(FirstDivisor)) begin
            res_prime_d = '0;
            res_exp_d   = '0;
            res_last_d  = 1'b1;
            state_d     = ST_EMIT;
          end else begin
            state_d = ST_TEST;
          end
        end
      end
      ST_TEST: begin
        if (sq_q <= SqWidth'(n_q)) begin
          state_d = ST_DIV_START;
        end else begin
          // No candidate left: what remains above one is itself prime.
          res_prime_d = n_q;
          res_exp_d   = ExpWidth'(1);
          res_last_d  = 1'b1;
          state_d     = ST_EMIT;
        end
      end
      ST_DIV_START: begin
        div_req.start = 1'b1;
        state_d       = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.remainder == '0) begin
            n_d     = div_rsp.quotient;
            e_d     = e_q + 1'b1;
            state_d = ST_DIV_START;
          end else if (e_q != '0) begin
            // A leftover above one always yields another result, unless the cap is hit.
            res_prime_d = dv_q;
            res_exp_d   = e_q;
            res_last_d  = (n_q == ValueWidth'(1)) ||
                          (cnt_q == ResCntWidth'(MaxResults - 1));
            state_d     = ST_EMIT;
          end else begin
            dv_d    = dv_q + 1'b1;
            sq_d    = sq_q + SqWidth'({dv_q, 1'b1});
            state_d = ST_TEST;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_prime_d = PrimeWidth'(res_prime_q);
          out_exp_d   = res_exp_q;
          out_last_d  = res_last_q;
          cnt_d       = cnt_q + 1'b1;
          if (res_last_q) begin
            state_d = ST_IDLE;
          end else begin
            dv_d    = dv_q + 1'b1;
            sq_d    = sq_q + SqWidth'({dv_q, 1'b1});
            e_d     = '0;
            state_d = ST_TEST;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    dv_q        <= dv_d;
    sq_q        <= sq_d;
    e_q         <= e_d;
    cnt_q       <= cnt_d;
    res_prime_q <= res_prime_d;
    res_exp_q   <= res_exp_d;
    res_last_q  <= res_last_d;
    out_prime_q <= out_prime_d;
    out_exp_q   <= out_exp_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign prime_o     = out_prime_q;
  assign exponent_o  = out_exp_q;
  assign last_o      = out_last_q;

endmodule

// ===== src/tdf_checker.sv =====
// Port-level checks for the factorizer and their binding to the top level.
module tdf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic [tdf_pkg::ValueWidth-1:0] value_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [tdf_pkg::PrimeWidth-1:0] prime_o,
  input logic [tdf_pkg::ExpWidth-1:0]   exponent_o,
  input logic                           last_o
);
  import tdf_pkg::*;

  // A stalled result beat stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // An accepted input raises in_stall_o; only that rise is checked here, not how long it lasts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while an item is in flight");

  // Exponent zero only marks the single result of an input below two.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (exponent_o == '0) |-> (prime_o == '0) && last_o)
    else $error("empty result that is not the lone last beat");

  // Results ahead of the last one are real divisors.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> (exponent_o != '0) &&
                                (prime_o >= PrimeWidth'(FirstDivisor)))
    else $error("non-final result without a proper prime");

endmodule

bind trial_division_factorizer_unit tdf_checker u_tdf_checker (.*);

// ===== verif/tdf_factor_scoreboard.sv =====
// Scoreboard for the trial-division factorizer: predicts prime factors and checks each beat.
`timescale 1ns / 100ps

module tdf_factor_scoreboard (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [tdf_pkg::ValueWidth-1:0] value_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [tdf_pkg::PrimeWidth-1:0] prime_i,
  input  logic [tdf_pkg::ExpWidth-1:0]   exponent_i,
  input  logic                           last_i,
  output int                             mismatch_count_o,
  output int                             pending_beats_o
);

  typedef logic [tdf_pkg::PrimeWidth-1:0] prime_t;
  typedef logic [tdf_pkg::ExpWidth-1:0]   exp_t;

  typedef struct packed {
    prime_t prime;
    exp_t   exponent;
    logic   last;
  } factor_beat_t;

  factor_beat_t expected_factors[$];

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    mismatch_count_o++;
  endtask

  // Factor one value by trial division and queue one beat per distinct prime.
  function automatic void predict_factors(input tdf_pkg::value_t value);
    longint unsigned rest;
    longint unsigned div;
    int unsigned     exp_cnt;
    factor_beat_t    beat;
    factor_beat_t    beats[$];
    rest = value;
    div  = tdf_pkg::FirstDivisor;
    if (rest < 2) begin
      beat = '{prime: '0, exponent: '0, last: 1'b1};
      expected_factors.push_back(beat);
      return;
    end
    while (div * div <= rest && beats.size() < tdf_pkg::MaxResults) begin
      if (rest % div == 0) begin
        exp_cnt = 0;
        while (rest % div == 0) begin
          rest = rest / div;
          exp_cnt++;
        end
        beat = '{prime: prime_t'(div), exponent: exp_t'(exp_cnt), last: 1'b0};
        beats.push_back(beat);
      end
      div++;
    end
    // Whatever is left above one after the search is itself prime.
    if (rest > 1 && beats.size() < tdf_pkg::MaxResults) begin
      beat = '{prime: prime_t'(rest), exponent: exp_t'(1), last: 1'b0};
      beats.push_back(beat);
    end
    foreach (beats[k]) begin
      beat      = beats[k];
      beat.last = (k == beats.size() - 1);
      expected_factors.push_back(beat);
    end
  endfunction

  always @(posedge clk_i) begin
    factor_beat_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_factors.size() == 0) begin
          report_mismatch($sformatf("unexpected beat prime %0d exponent %0d last %0b",
                                    prime_i, exponent_i, last_i));
        end else begin
          want = expected_factors.pop_front();
          if (prime_i !== want.prime)
            report_mismatch($sformatf("prime %0d, expected %0d", prime_i, want.prime));
          if (exponent_i !== want.exponent)
            report_mismatch($sformatf("exponent %0d for prime %0d, expected %0d",
                                      exponent_i, want.prime, want.exponent));
          if (last_i !== want.last)
            report_mismatch($sformatf("last %0b for prime %0d, expected %0b",
                                      last_i, want.prime, want.last));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_factors(value_i);
      end
      pending_beats_o <= expected_factors.size();
    end
  end

endmodule

// ===== verif/trial_division_factorizer_unit_tb.sv =====
// Testbench top for the trial-division factorizer: stimulus, output stalls and the verdict.
`timescale 1ns / 100ps

module trial_division_factorizer_unit_tb;

  localparam int unsigned RandomItems = 81;
  localparam int unsigned HoldCycles  = 600;
  localparam int unsigned TailCycles  = 100;
  localparam longint      LimitNs     = 80_000_000;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic [tdf_pkg::ValueWidth-1:0] value_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic [tdf_pkg::PrimeWidth-1:0] prime_o;
  logic [tdf_pkg::ExpWidth-1:0]   exponent_o;
  logic                           last_o;

  int   mismatch_count;
  int   pending_beats;

  trial_division_factorizer_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .prime_o     (prime_o),
    .exponent_o  (exponent_o),
    .last_o      (last_o)
  );

  tdf_factor_scoreboard u_scoreboard (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .value_i          (value_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .prime_i          (prime_o),
    .exponent_i       (exponent_o),
    .last_i           (last_o),
    .mismatch_count_o (mismatch_count),
    .pending_beats_o  (pending_beats)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Hold the value on the port until the block takes the beat.
  task automatic send_value(input tdf_pkg::value_t value);
    value_i    <= value;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Mostly back-to-back beats, sometimes a short gap, now and then a long one.
  task automatic idle_gap();
    int unsigned pick;
    int unsigned gap;
    pick = $urandom_range(0, 9);
    gap  = (pick < 5) ? 0 : (pick < 8) ? $urandom_range(1, 3) : $urandom_range(20, 60);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      value_i    <= tdf_pkg::value_t'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    @(posedge clk_i);
    while (pending_beats != 0) @(posedge clk_i);
  endtask

  // Smooth numbers give many distinct primes; small values keep the search short.
  function automatic tdf_pkg::value_t random_value();
    int unsigned pick;
    int unsigned v;
    int unsigned p;
    int unsigned smooth_primes[10] = '{2, 3, 5, 7, 11, 13, 17, 19, 251, 257};
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      v = 1;
      repeat ($urandom_range(1, 10)) begin
        p = smooth_primes[$urandom_range(0, 9)];
        if (v * p <= 65535) v = v * p;
      end
    end else if (pick < 7) begin
      v = $urandom_range(0, 1023);
    end else begin
      v = $urandom_range(0, 65535);
    end
    return tdf_pkg::value_t'(v);
  endfunction

  initial begin : stimulus
    tdf_pkg::value_t corner_values[$] = '{
      16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd8, 16'd36, 16'd49, 16'd97,
      16'd32768, 16'd30030, 16'd60060, 16'd65025, 16'd65534, 16'd65535,
      16'hAAAA, 16'h5555, 16'd65521
    };
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    value_i      = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The first few values are quick to factor, so they soon run into the hold and stall the input.
    foreach (corner_values[i]) begin
      send_value(corner_values[i]);
      idle_gap();
    end
    in_valid_i <= 1'b0;
    drain_results();

    repeat (RandomItems) begin
      send_value(random_value());
      idle_gap();
    end
    in_valid_i <= 1'b0;
    drain_results();
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : result_stalls
    int unsigned pick;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    // A long hold right after reset lets the block fill up and stall its input.
    out_stall_i <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    forever begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        repeat ($urandom_range(10, 100)) begin
          out_stall_i <= 1'b0;
          @(posedge clk_i);
        end
      end else if (pick < 8) begin
        repeat ($urandom_range(10, 40)) begin
          out_stall_i <= ($urandom_range(0, 2) == 0);
          @(posedge clk_i);
        end
      end else begin
        repeat ($urandom_range(20, 80)) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin : watchdog
    #(LimitNs);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
src/tdf_pkg.sv
src/tdf_divider.sv
src/trial_division_factorizer_unit.sv
src/tdf_checker.sv
verif/tdf_factor_scoreboard.sv
verif/trial_division_factorizer_unit_tb.sv
